[design/ptmld_pkg.sv]
// ============================================================================
// Packed tile map line drawer package
// Shared widths, tile packing constants, command codes and the records that
// pass between the front end, the command queue and the back end.
// ============================================================================
package ptmld_pkg;

    // Coordinates are full bytes; tiles are two-bit codes packed four to a byte.
    localparam int COORD_W       = 8;
    localparam int TILE_W        = 2;
    localparam int BITS_PER_TILE = 2;
    localparam logic [TILE_W-1:0] TILE_MASK = 2'b11;

    // Command queue depth. It must be a power of two so the pointers wrap.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef enum logic {
        ACT_DRAW = 1'b0,
        ACT_READ = 1'b1
    } t_action;

    // A classified command: the line deltas and step directions are worked
    // out once at the front so the back end only iterates.
    typedef struct packed {
        t_action             action;
        logic [COORD_W-1:0]  x0;
        logic [COORD_W-1:0]  y0;
        logic [COORD_W-1:0]  adx;
        logic [COORD_W-1:0]  ady;
        logic [COORD_W-1:0]  span;
        logic                neg_x;
        logic                neg_y;
        logic [TILE_W-1:0]   code;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

[design/ptmld_front.sv]
// ============================================================================
// Front end
// Accepts command beats and classifies them: absolute deltas, major distance
// and step directions, pushed into the command queue.
// ============================================================================
module ptmld_front (
    input  logic                                i_start,
    input  logic                                i_action,
    input  logic [ptmld_pkg::COORD_W-1:0]       i_start_x,
    input  logic [ptmld_pkg::COORD_W-1:0]       i_start_y,
    input  logic [ptmld_pkg::COORD_W-1:0]       i_end_x,
    input  logic [ptmld_pkg::COORD_W-1:0]       i_end_y,
    input  logic [ptmld_pkg::TILE_W-1:0]        i_tile_code,
    input  ptmld_pkg::t_q_status                i_q_stat,
    input  logic                                i_clearing,
    output logic                                o_busy,
    output logic                                o_push,
    output ptmld_pkg::t_cmd                     o_cmd
);

    logic [ptmld_pkg::COORD_W-1:0] adx;
    logic [ptmld_pkg::COORD_W-1:0] ady;

    assign o_busy = i_clearing || i_q_stat.full;
    assign o_push = i_start && !o_busy;

    assign adx = (i_end_x >= i_start_x) ? (i_end_x - i_start_x) : (i_start_x - i_end_x);
    assign ady = (i_end_y >= i_start_y) ? (i_end_y - i_start_y) : (i_start_y - i_end_y);

    always_comb begin
        o_cmd.action = ptmld_pkg::t_action'(i_action);
        o_cmd.x0     = i_start_x;
        o_cmd.y0     = i_start_y;
        o_cmd.adx    = adx;
        o_cmd.ady    = ady;
        o_cmd.span   = (adx > ady) ? adx : ady;
        o_cmd.neg_x  = i_end_x < i_start_x;
        o_cmd.neg_y  = i_end_y < i_start_y;
        o_cmd.code   = i_tile_code;
    end

endmodule

[design/ptmld_fifo.sv]
// ============================================================================
// Command queue
// A short first-in first-out queue of classified commands between the front
// end and the back end, with the head shown ahead of the pop.
// ============================================================================
module ptmld_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ptmld_pkg::t_cmd        i_cmd,
    input  logic                   i_pop,
    output ptmld_pkg::t_cmd        o_head,
    output ptmld_pkg::t_q_status   o_stat
);

    ptmld_pkg::t_cmd                r_entry [ptmld_pkg::Q_DEPTH];
    logic [ptmld_pkg::Q_PTR_W-1:0]  r_wptr;
    logic [ptmld_pkg::Q_PTR_W-1:0]  r_rptr;
    logic [ptmld_pkg::Q_PTR_W:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_cmd;
        end
    end

    assign o_head       = r_entry[r_rptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (ptmld_pkg::Q_PTR_W+1)'(ptmld_pkg::Q_DEPTH));

endmodule

[design/ptmld_back.sv]
// ============================================================================
// Back end
// Owns the packed tile store. Clears it after reset, then takes commands from
// the queue: walks a line point by point with a read-modify-write per point
// on the map, or reads one tile, and issues the result beat.
// ============================================================================
module ptmld_back #(
    parameter int MAP_COLS = 32,
    parameter int MAP_ROWS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ptmld_pkg::t_cmd                 i_head,
    input  ptmld_pkg::t_q_status            i_q_stat,
    output logic                            o_pop,
    output logic                            o_clearing,
    output logic                            o_valid,
    output logic [ptmld_pkg::TILE_W-1:0]    o_tile_value
);

    localparam int ROW_BYTES   = (MAP_COLS + 3) / 4;
    localparam int STORE_BYTES = ROW_BYTES * MAP_ROWS;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CLR_W       = $clog2(STORE_BYTES + 1);
    localparam int CW          = ptmld_pkg::COORD_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_POINT,
        S_MODIFY,
        S_READ_OUT
    } t_state;

    t_state                         r_state;
    logic [CLR_W-1:0]               r_clr;
    ptmld_pkg::t_action             r_action;
    logic [CW-1:0]                  r_px;
    logic [CW-1:0]                  r_py;
    logic [CW-1:0]                  r_adx;
    logic [CW-1:0]                  r_ady;
    logic [CW-1:0]                  r_dist;
    logic                           r_negx;
    logic                           r_negy;
    logic [ptmld_pkg::TILE_W-1:0]   r_code;
    logic [CW-1:0]                  r_ex;
    logic [CW-1:0]                  r_ey;
    logic [CW:0]                    r_left;
    logic [ADDR_W-1:0]              r_addr;
    logic                           r_valid;
    logic [ptmld_pkg::TILE_W-1:0]   r_value;
    logic [7:0]                     r_store [STORE_BYTES];
    logic [7:0]                     r_rdata;

    logic                           in_map;
    logic [15:0]                    addr_full;
    logic [ADDR_W-1:0]              pt_addr;
    logic [2:0]                     tile_sh;
    logic [7:0]                     mod_byte;
    logic [ptmld_pkg::TILE_W-1:0]   rd_tile;
    logic [CW:0]                    ex_sum;
    logic [CW:0]                    ey_sum;
    logic                           ex_step;
    logic                           ey_step;
    logic [CW-1:0]                  ex_next;
    logic [CW-1:0]                  ey_next;
    logic [CW-1:0]                  px_next;
    logic [CW-1:0]                  py_next;
    logic                           last_pt;
    logic                           mem_we;
    logic [ADDR_W-1:0]              mem_waddr;
    logic [7:0]                     mem_wdata;
    logic                           mem_re;

    // Point addressing and tile packing.
    assign in_map    = ({1'b0, r_px} < (CW+1)'(MAP_COLS)) && ({1'b0, r_py} < (CW+1)'(MAP_ROWS));
    assign addr_full = 16'(r_py) * 16'(ROW_BYTES) + 16'(r_px[CW-1:2]);
    assign pt_addr   = addr_full[ADDR_W-1:0];
    assign tile_sh   = 3'(r_px[1:0] * ptmld_pkg::BITS_PER_TILE);
    assign mod_byte  = (r_rdata & ~(8'(ptmld_pkg::TILE_MASK) << tile_sh))
                     | (8'(r_code) << tile_sh);
    assign rd_tile   = ptmld_pkg::TILE_W'(r_rdata >> tile_sh) & ptmld_pkg::TILE_MASK;

    // Accumulator step for both axes.
    assign ex_sum  = {1'b0, r_ex} + {1'b0, r_adx};
    assign ey_sum  = {1'b0, r_ey} + {1'b0, r_ady};
    assign ex_step = ex_sum > {1'b0, r_dist};
    assign ey_step = ey_sum > {1'b0, r_dist};
    assign ex_next = ex_step ? CW'(ex_sum - {1'b0, r_dist}) : ex_sum[CW-1:0];
    assign ey_next = ey_step ? CW'(ey_sum - {1'b0, r_dist}) : ey_sum[CW-1:0];
    assign px_next = !ex_step ? r_px : (r_negx ? r_px - 1'b1 : r_px + 1'b1);
    assign py_next = !ey_step ? r_py : (r_negy ? r_py - 1'b1 : r_py + 1'b1);
    assign last_pt = (r_left == '0);

    assign o_pop      = (r_state == S_IDLE) && !i_q_stat.empty;
    assign o_clearing = (r_state == S_CLEAR);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = mod_byte;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr[ADDR_W-1:0];
            mem_wdata = '0;
        end else if (r_state == S_MODIFY) begin
            mem_we = 1'b1;
        end
    end

    assign mem_re = (r_state == S_POINT) && in_map;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_store[pt_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_value <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLR_W'(STORE_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_action <= i_head.action;
                        r_px     <= i_head.x0;
                        r_py     <= i_head.y0;
                        r_adx    <= i_head.adx;
                        r_ady    <= i_head.ady;
                        r_dist   <= i_head.span;
                        r_negx   <= i_head.neg_x;
                        r_negy   <= i_head.neg_y;
                        r_code   <= i_head.code;
                        r_ex     <= '0;
                        r_ey     <= '0;
                        r_left   <= {1'b0, i_head.span} + 1'b1;
                        r_state  <= S_POINT;
                    end
                end
                S_POINT: begin
                    r_addr <= pt_addr;
                    if (r_action == ptmld_pkg::ACT_READ) begin
                        if (in_map) begin
                            r_state <= S_READ_OUT;
                        end else begin
                            r_valid <= 1'b1;
                            r_value <= '0;
                            r_state <= S_IDLE;
                        end
                    end else if (in_map) begin
                        r_state <= S_MODIFY;
                    end else begin
                        r_px   <= px_next;
                        r_py   <= py_next;
                        r_ex   <= ex_next;
                        r_ey   <= ey_next;
                        r_left <= r_left - 1'b1;
                        if (last_pt) begin
                            r_valid <= 1'b1;
                            r_value <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MODIFY: begin
                    r_px   <= px_next;
                    r_py   <= py_next;
                    r_ex   <= ex_next;
                    r_ey   <= ey_next;
                    r_left <= r_left - 1'b1;
                    if (last_pt) begin
                        r_valid <= 1'b1;
                        r_value <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_POINT;
                    end
                end
                S_READ_OUT: begin
                    r_valid <= 1'b1;
                    r_value <= rd_tile;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_valid;
    assign o_tile_value = r_value;

endmodule

[design/packed_tile_map_line_drawer.sv]
// ============================================================================
// Packed tile map line drawer
// Keeps a map of two-bit tile codes packed four to a byte, draws lines into
// it and reads single tiles back.
// ============================================================================
// A command beat is taken at a rising edge where start is high and busy is
// low, and every command produces exactly one result beat: o_valid is high
// for one cycle with o_tile_value, and that beat cannot be held off, so the
// receiver must take it when it appears. After reset the block sweeps the
// whole tile store to zero, one byte per cycle, holding busy high until the
// sweep is done. Commands then pass through a two-deep queue: busy stays
// low until the queue is full, so up to two commands can wait while a third
// is being executed. A draw command walks the line over d+2 points, where d
// is the larger of the absolute column and row deltas; each point on the map
// costs a read and a write of the single-port store, and each point off the
// map is dropped without a store access. The command is loaded from the
// queue before its first point. A read looks up one tile in the store when
// it is on the map. The store's read-modify-write per point sets the rate.
// A draw returns a tile value of zero; a read outside the map returns zero.

module packed_tile_map_line_drawer #(
    parameter int MAP_COLS = 32,
    parameter int MAP_ROWS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    input  logic                            i_action,
    input  logic [ptmld_pkg::COORD_W-1:0]   i_start_x,
    input  logic [ptmld_pkg::COORD_W-1:0]   i_start_y,
    input  logic [ptmld_pkg::COORD_W-1:0]   i_end_x,
    input  logic [ptmld_pkg::COORD_W-1:0]   i_end_y,
    input  logic [ptmld_pkg::TILE_W-1:0]    i_tile_code,
    output logic                            busy,
    output logic                            o_valid,
    output logic [ptmld_pkg::TILE_W-1:0]    o_tile_value
);

    // Classified command from the front end into the queue.
    ptmld_pkg::t_cmd        cmd_in;
    logic                   cmd_push;
    // Queue head and fill status toward the back end.
    ptmld_pkg::t_cmd        cmd_head;
    ptmld_pkg::t_q_status   q_stat;
    logic                   cmd_pop;
    // The back end holds the front off while the store is being cleared.
    logic                   clearing;

    // The front end works out the deltas and step directions at accept time,
    // so the back end only loads them and iterates.
    ptmld_front u_front (
        .i_start     (start),
        .i_action    (i_action),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_tile_code (i_tile_code),
        .i_q_stat    (q_stat),
        .i_clearing  (clearing),
        .o_busy      (busy),
        .o_push      (cmd_push),
        .o_cmd       (cmd_in)
    );

    // The queue decouples command intake from line drawing.
    ptmld_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_head  (cmd_head),
        .o_stat  (q_stat)
    );

    // The back end owns the tile store and issues every result beat.
    ptmld_back #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (cmd_head),
        .i_q_stat     (q_stat),
        .o_pop        (cmd_pop),
        .o_clearing   (clearing),
        .o_valid      (o_valid),
        .o_tile_value (o_tile_value)
    );

endmodule

[design/ptmld_checker.sv]
// ============================================================================
// Port checker
// Watches the top level's ports: result beats never outnumber accepted
// command beats, and the block never holds more commands than it can store.
// ============================================================================
module ptmld_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    logic [2:0] r_pending;
    logic       accept;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (accept && !o_valid) begin
            r_pending <= r_pending + 1'b1;
        end else if (o_valid && !accept) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    // Reset drops any result beat in flight.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    // Every result beat answers an earlier command beat.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_pending != '0))
        else $error("result beat with no outstanding command");

    // Two queued commands and one in execution at most.
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 3'd3)
        else $error("more commands outstanding than the block can hold");

    // Each result returns the back end to idle, so results never come back to back.
    a_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beats in consecutive cycles");

endmodule

bind packed_tile_map_line_drawer ptmld_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

[sim/packed_tile_map_line_drawer_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// Packed tile map line drawer testbench
// Drives draw and read command beats into the block and predicts each
// result from a private copy of the packed tile map, checking every result
// beat in order. The run is a short directed part followed by random
// commands under several sender idling phases.
// ============================================================================
module packed_tile_map_line_drawer_test;

    localparam int COORD_W       = ptmld_pkg::COORD_W;
    localparam int TILE_W        = ptmld_pkg::TILE_W;
    localparam int BITS_PER_TILE = ptmld_pkg::BITS_PER_TILE;
    localparam logic [TILE_W-1:0] TILE_MASK = ptmld_pkg::TILE_MASK;

    localparam int MAP_COLS    = 32;
    localparam int MAP_ROWS    = 32;
    localparam int ROW_BYTES   = (MAP_COLS + 3) / 4;
    localparam int STORE_BYTES = ROW_BYTES * MAP_ROWS;
    localparam int CLK_HALF    = 4;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_PER_PHASE = 425;
    localparam int DRAIN_CYCLES = 40;
    // The slowest legal run is about 1750 commands, each a full-range line,
    // with long sender gaps; this limit sits several times above it.
    localparam int CYCLE_LIMIT = 6000000;

    // One command beat as the block sees it on its input ports.
    typedef struct {
        ptmld_pkg::t_action  action;
        logic [COORD_W-1:0]  sx;
        logic [COORD_W-1:0]  sy;
        logic [COORD_W-1:0]  ex;
        logic [COORD_W-1:0]  ey;
        logic [TILE_W-1:0]   code;
    } t_tile_cmd;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                i_action = 1'b0;
    logic [COORD_W-1:0]  i_start_x = '0;
    logic [COORD_W-1:0]  i_start_y = '0;
    logic [COORD_W-1:0]  i_end_x = '0;
    logic [COORD_W-1:0]  i_end_y = '0;
    logic [TILE_W-1:0]   i_tile_code = '0;
    logic                busy;
    logic                o_valid;
    logic [TILE_W-1:0]   o_tile_value;

    // Commands waiting to be driven, the command now on the ports, and the
    // tile values that the block still owes us, oldest first.
    t_tile_cmd           pending_cmds[$];
    t_tile_cmd           cmd_on_ports;
    logic [TILE_W-1:0]   expected_values[$];

    // Private copy of the packed map: four tiles per byte, tile x of a row at
    // bit (x % 4) * 2 of byte x / 4.
    logic [7:0]          map_bytes[STORE_BYTES];

    int                  sender_idle_pct = 0;
    int                  mismatch_count = 0;
    longint              cycle_count = 0;

    packed_tile_map_line_drawer #(
        .MAP_COLS (MAP_COLS),
        .MAP_ROWS (MAP_ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_action     (i_action),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_tile_code  (i_tile_code),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_tile_value (o_tile_value)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Applies one command to the private map and returns the tile value the
    // block should report for it. Lines follow the accumulator walk: d + 2
    // points, the start point written twice, off-map points dropped.
    function automatic logic [TILE_W-1:0] apply_tile_cmd(t_tile_cmd c);
        int px, py, step_x, step_y, adx, ady, span, acc_x, acc_y, idx, sh;
        logic [TILE_W-1:0] value;
        value = '0;
        if (c.action == ptmld_pkg::ACT_READ) begin
            if (c.sx < MAP_COLS && c.sy < MAP_ROWS) begin
                idx = int'(c.sy) * ROW_BYTES + int'(c.sx) / 4;
                sh = (int'(c.sx) % 4) * BITS_PER_TILE;
                value = TILE_W'(map_bytes[idx] >> sh) & TILE_MASK;
            end
        end else begin
            px = int'(c.sx);
            py = int'(c.sy);
            step_x = (c.ex > c.sx) ? 1 : ((c.ex < c.sx) ? -1 : 0);
            step_y = (c.ey > c.sy) ? 1 : ((c.ey < c.sy) ? -1 : 0);
            adx = (c.ex >= c.sx) ? int'(c.ex) - int'(c.sx) : int'(c.sx) - int'(c.ex);
            ady = (c.ey >= c.sy) ? int'(c.ey) - int'(c.sy) : int'(c.sy) - int'(c.ey);
            span = (adx > ady) ? adx : ady;
            acc_x = 0;
            acc_y = 0;
            for (int t = 0; t <= span + 1; t++) begin
                if (px >= 0 && py >= 0 && px < MAP_COLS && py < MAP_ROWS) begin
                    idx = py * ROW_BYTES + px / 4;
                    sh = (px % 4) * BITS_PER_TILE;
                    map_bytes[idx] = (map_bytes[idx] & ~(8'(TILE_MASK) << sh))
                                     | (8'(c.code) << sh);
                end
                acc_x += adx;
                acc_y += ady;
                if (acc_x > span) begin
                    acc_x -= span;
                    px += step_x;
                end
                if (acc_y > span) begin
                    acc_y -= span;
                    py += step_y;
                end
            end
        end
        return value;
    endfunction

    task automatic push_cmd(ptmld_pkg::t_action act, int sx, int sy, int ex, int ey,
                            int code);
        t_tile_cmd c;
        c.action = act;
        c.sx = COORD_W'(sx);
        c.sy = COORD_W'(sy);
        c.ex = COORD_W'(ex);
        c.ey = COORD_W'(ey);
        c.code = TILE_W'(code);
        pending_cmds.push_back(c);
    endtask

    function automatic int clamp_coord(int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    // Random commands lean on the map area so that reads mostly land on
    // tiles that earlier lines wrote. Long lines over the whole coordinate
    // range are kept to a small share since they are slow.
    task automatic push_random_cmd();
        int pick, sx, sy, ex, ey;
        ptmld_pkg::t_action act;
        pick = $urandom_range(99);
        act = (pick < 45) ? ptmld_pkg::ACT_READ : ptmld_pkg::ACT_DRAW;
        ex = $urandom_range(255);
        ey = $urandom_range(255);
        if (pick < 38 || (pick >= 45 && pick < 75)) begin
            sx = $urandom_range(MAP_COLS + 3);
            sy = $urandom_range(MAP_ROWS + 3);
            if (act == ptmld_pkg::ACT_DRAW) begin
                ex = $urandom_range(MAP_COLS + 3);
                ey = $urandom_range(MAP_ROWS + 3);
            end
        end else if (pick >= 75 && pick < 88) begin
            sx = $urandom_range(MAP_COLS + 4);
            sy = $urandom_range(MAP_ROWS + 4);
            ex = clamp_coord(sx + int'($urandom_range(12)) - 6);
            ey = clamp_coord(sy + int'($urandom_range(12)) - 6);
        end else begin
            sx = $urandom_range(255);
            sy = $urandom_range(255);
        end
        push_cmd(act, sx, sy, ex, ey, $urandom_range(3));
    endtask

    // Driver. A beat is taken at an edge where start is high and busy is low;
    // it is predicted right there, since the block works its commands in
    // order. After a taken beat, or while start is low, the next command may
    // go out, unless the sender chooses to idle this cycle.
    always @(posedge i_clk) begin
        t_tile_cmd next_cmd;
        logic slot_free;
        if (i_rst_n) begin
            slot_free = !start || !busy;
            if (start && !busy)
                expected_values.push_back(apply_tile_cmd(cmd_on_ports));
            if (slot_free) begin
                if (pending_cmds.size() != 0 &&
                    int'($urandom_range(99)) >= sender_idle_pct) begin
                    next_cmd = pending_cmds.pop_front();
                    cmd_on_ports = next_cmd;
                    i_action    <= next_cmd.action;
                    i_start_x   <= next_cmd.sx;
                    i_start_y   <= next_cmd.sy;
                    i_end_x     <= next_cmd.ex;
                    i_end_y     <= next_cmd.ey;
                    i_tile_code <= next_cmd.code;
                    start       <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each result beat lives for one cycle and is compared with the
    // oldest expected tile value; a beat with nothing waiting is a failure.
    always @(posedge i_clk) begin
        logic [TILE_W-1:0] want;
        if (i_rst_n && o_valid) begin
            if (expected_values.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat: tile_value %0d", o_tile_value);
            end else begin
                want = expected_values.pop_front();
                if (o_tile_value !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("tile_value mismatch: expected %0d, got %0d",
                                 want, o_tile_value);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Waits until every queued command has gone out and every result is in.
    task automatic wait_until_drained();
        while (pending_cmds.size() != 0 || start) @(posedge i_clk);
        while (expected_values.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int phase_idle[4];
        phase_idle = '{0, 68, 0, 25};
        for (int i = 0; i < STORE_BYTES; i++)
            map_bytes[i] = 8'h00;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: map corners and edges, reads off the map, a
        // zero-length line, lines over the whole 0..255 range in both
        // directions, steep and shallow lines, and a line entirely off the map.
        push_cmd(ptmld_pkg::ACT_READ, 0, 0, 255, 255, 3);
        push_cmd(ptmld_pkg::ACT_DRAW, 0, 0, 0, 0, 3);
        push_cmd(ptmld_pkg::ACT_READ, 0, 0, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_READ, 1, 0, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_DRAW, 0, 5, 255, 5, 2);
        push_cmd(ptmld_pkg::ACT_READ, 31, 5, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_READ, 32, 5, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_DRAW, 255, 255, 0, 0, 1);
        push_cmd(ptmld_pkg::ACT_READ, 31, 31, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_READ, 17, 17, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_DRAW, 30, 0, 30, 255, 3);
        push_cmd(ptmld_pkg::ACT_READ, 30, 31, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_READ, 30, 32, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_DRAW, 2, 1, 9, 29, 2);
        push_cmd(ptmld_pkg::ACT_READ, 9, 29, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_DRAW, 28, 3, 1, 12, 1);
        push_cmd(ptmld_pkg::ACT_READ, 1, 12, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_DRAW, 200, 100, 60, 240, 3);
        push_cmd(ptmld_pkg::ACT_DRAW, 31, 31, 31, 31, 0);
        push_cmd(ptmld_pkg::ACT_READ, 31, 31, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_READ, 255, 255, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_READ, 0, 255, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_DRAW, 40, 2, 0, 2, 3);
        push_cmd(ptmld_pkg::ACT_READ, 3, 2, 0, 0, 0);
        push_cmd(ptmld_pkg::ACT_READ, 4, 2, 0, 0, 0);
        wait_until_drained();

        // Random part, one slice per sender idling phase.
        foreach (phase_idle[p]) begin
            sender_idle_pct = phase_idle[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                push_random_cmd();
            wait_until_drained();
        end

        // Let any stray result beat show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_values.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[packed_tile_map_line_drawer.f]
design/ptmld_pkg.sv
design/ptmld_front.sv
design/ptmld_fifo.sv
design/ptmld_back.sv
design/packed_tile_map_line_drawer.sv
design/ptmld_checker.sv
sim/packed_tile_map_line_drawer_test.sv
